@@ sv/hrsp_pkg.sv @@
package hrsp_pkg;

    localparam logic [7:0] COLON_CHAR = 8'h3A;
    localparam logic [7:0] EOF_TYPE   = 8'h01;

    typedef enum logic [2:0] {
        PH_WAIT,
        PH_COUNT,
        PH_ADDR,
        PH_TYPE,
        PH_DATA,
        PH_CSUM,
        PH_HALT
    } phase_t;

    typedef enum logic [2:0] {
        RK_DATA    = 3'd0,
        RK_OK      = 3'd1,
        RK_BAD_SUM = 3'd2,
        RK_EOF     = 3'd3,
        RK_BAD_HEX = 3'd4
    } res_kind_t;

    // One classified character as it travels from the front to the back.
    typedef struct packed {
        logic       is_colon;
        logic       is_hex;
        logic [3:0] nib;
    } class_t;

    typedef struct packed {
        res_kind_t   kind;
        logic [15:0] addr;
        logic [7:0]  data;
        logic [7:0]  rkind;
    } result_t;

endpackage

@@ sv/hex_record_stream_parser_core.sv @@
// Intel HEX record parser, one ASCII character per beat. Characters before a
// colon are skipped; after it the block reads count, address, type, data and
// checksum as hex pairs, emits each data byte with its wrapped 16-bit address,
// and reports record accepted, checksum mismatch, end of file or bad hex digit.
// After end of file, a mismatch or a bad digit every character is dropped
// until reset. Input and results both behave like queues: a character enters
// on push while full is low, and a result leaves on pop while empty is low.
// Throughput is one character per clock while full is low; a character passes
// the classifier register, then the character queue, then the parser into the
// result queue before the result it causes can be popped. The parser handles
// one character per clock out of the queue and holds only while the two-entry
// result queue is full; the character queue (QUEUE_DEPTH entries) absorbs those
// holds before full rises.
module hex_record_stream_parser_core
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  in_char,
    output logic        empty,
    input  logic        pop,
    output logic [2:0]  result_kind,
    output logic [15:0] byte_address,
    output logic [7:0]  data_byte,
    output logic [7:0]  record_kind
);
    import hrsp_pkg::*;

    logic    fq_push;
    logic    fq_full;
    class_t  fq_item;
    logic    bq_pop;
    logic    bq_empty;
    class_t  bq_item;
    result_t res;

    // Classify each character and hold it until the queue takes it.
    hrsp_front u_front
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .full    (full),
        .in_char (in_char),
        .q_push  (fq_push),
        .q_full  (fq_full),
        .q_item  (fq_item)
    );

    // Decouple classification from parsing so each side stalls on its own.
    hrsp_queue
    #(
        .DEPTH (QUEUE_DEPTH)
    )
    u_queue
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (fq_push),
        .wr_item (fq_item),
        .full    (fq_full),
        .rd_en   (bq_pop),
        .rd_item (bq_item),
        .empty   (bq_empty)
    );

    // Run the record state machine and queue results for the consumer.
    hrsp_back u_back
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_empty (bq_empty),
        .q_item  (bq_item),
        .q_pop   (bq_pop),
        .pop     (pop),
        .empty   (empty),
        .res_out (res)
    );

    assign result_kind  = res.kind;
    assign byte_address = res.addr;
    assign data_byte    = res.data;
    assign record_kind  = res.rkind;

endmodule

@@ sv/hrsp_front.sv @@
module hrsp_front
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    output logic                full,
    input  logic [7:0]          in_char,
    output logic                q_push,
    input  logic                q_full,
    output hrsp_pkg::class_t    q_item
);
    import hrsp_pkg::*;

    logic   valid_reg;
    logic   valid_next;
    class_t item_reg;
    class_t item_next;
    logic   accept;

    // Decode one character into colon flag, hex flag and nibble value.
    always_comb
    begin
        item_next.is_colon = (in_char == COLON_CHAR);
        item_next.is_hex   = 1'b1;
        item_next.nib      = 4'h0;
        if (in_char inside {[8'h30:8'h39]})
        begin
            item_next.nib = in_char[3:0];
        end
        else if (in_char inside {[8'h41:8'h46], [8'h61:8'h66]})
        begin
            item_next.nib = in_char[3:0] + 4'd9;
        end
        else
        begin
            item_next.is_hex = 1'b0;
        end
    end

    assign q_push = valid_reg && !q_full;
    assign full   = valid_reg && q_full;
    assign accept = push && !full;
    assign q_item = item_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (q_push)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= item_next;
        end
    end

endmodule

@@ sv/hrsp_queue.sv @@
module hrsp_queue
#(
    parameter int DEPTH = 4
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                wr_en,
    input  hrsp_pkg::class_t    wr_item,
    output logic                full,
    input  logic                rd_en,
    output hrsp_pkg::class_t    rd_item,
    output logic                empty
);
    import hrsp_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    class_t             mem [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_next;
    logic [CNT_W-1:0]   cnt_reg;
    logic [CNT_W-1:0]   cnt_next;
    logic               do_wr;
    logic               do_rd;

    assign full    = (cnt_reg == CNT_W'(DEPTH));
    assign empty   = (cnt_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_item = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem[wr_ptr_reg] <= wr_item;
        end
    end

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(DEPTH))
        else $error("queue count above depth");

endmodule

@@ sv/hrsp_back.sv @@
module hrsp_back
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_empty,
    input  hrsp_pkg::class_t    q_item,
    output logic                q_pop,
    input  logic                pop,
    output logic                empty,
    output hrsp_pkg::result_t   res_out
);
    import hrsp_pkg::*;

    phase_t      phase_reg, phase_next;
    logic [1:0]  nib_cnt_reg, nib_cnt_next;
    logic [11:0] high_reg, high_next;
    logic [7:0]  len_reg, len_next;
    logic [15:0] addr_reg, addr_next;
    logic [7:0]  type_reg, type_next;
    logic [7:0]  idx_reg, idx_next;
    logic [7:0]  sum_reg, sum_next;

    logic        consume;
    logic        last;
    logic [15:0] value;
    logic [7:0]  v8;
    logic        res_push;
    result_t     res_next;

    // Two-entry result queue.
    result_t     out_mem [2];
    logic        out_wr_reg, out_wr_next;
    logic        out_rd_reg, out_rd_next;
    logic [1:0]  out_cnt_reg, out_cnt_next;
    logic        out_pop;

    assign consume = !q_empty && (out_cnt_reg != 2'd2);
    assign q_pop   = consume;
    assign value   = {high_reg, q_item.nib};
    assign v8      = value[7:0];
    assign last    = (phase_reg == PH_ADDR) ? (nib_cnt_reg == 2'd3) : (nib_cnt_reg == 2'd1);

    always_comb
    begin
        phase_next   = phase_reg;
        nib_cnt_next = nib_cnt_reg;
        high_next    = high_reg;
        len_next     = len_reg;
        addr_next    = addr_reg;
        type_next    = type_reg;
        idx_next     = idx_reg;
        sum_next     = sum_reg;
        res_push     = 1'b0;
        res_next     = '{kind: RK_DATA, addr: 16'h0000, data: 8'h00, rkind: type_reg};
        if (consume)
        begin
            case (phase_reg)
                PH_HALT:
                begin
                end
                PH_WAIT:
                begin
                    if (q_item.is_colon)
                    begin
                        phase_next   = PH_COUNT;
                        nib_cnt_next = 2'd0;
                        high_next    = 12'h000;
                        len_next     = 8'h00;
                        addr_next    = 16'h0000;
                        type_next    = 8'h00;
                        idx_next     = 8'h00;
                        sum_next     = 8'h00;
                    end
                end
                default:
                begin
                    if (!q_item.is_hex)
                    begin
                        res_push      = 1'b1;
                        res_next.kind = RK_BAD_HEX;
                        phase_next    = PH_HALT;
                    end
                    else if (!last)
                    begin
                        high_next    = {high_reg[7:0], q_item.nib};
                        nib_cnt_next = nib_cnt_reg + 2'd1;
                    end
                    else
                    begin
                        nib_cnt_next = 2'd0;
                        high_next    = 12'h000;
                        case (phase_reg)
                            PH_COUNT:
                            begin
                                len_next   = v8;
                                sum_next   = sum_reg + v8;
                                phase_next = PH_ADDR;
                            end
                            PH_ADDR:
                            begin
                                addr_next  = value;
                                sum_next   = sum_reg + value[7:0] + value[15:8];
                                phase_next = PH_TYPE;
                            end
                            PH_TYPE:
                            begin
                                type_next = v8;
                                sum_next  = sum_reg + v8;
                                idx_next  = 8'h00;
                                if (v8 == EOF_TYPE)
                                begin
                                    res_push       = 1'b1;
                                    res_next.kind  = RK_EOF;
                                    res_next.rkind = v8;
                                    phase_next     = PH_HALT;
                                end
                                else
                                begin
                                    phase_next = (len_reg == 8'h00) ? PH_CSUM : PH_DATA;
                                end
                            end
                            PH_DATA:
                            begin
                                res_push      = 1'b1;
                                res_next.kind = RK_DATA;
                                res_next.addr = addr_reg + {8'h00, idx_reg};
                                res_next.data = v8;
                                sum_next      = sum_reg + v8;
                                idx_next      = idx_reg + 8'd1;
                                if ((idx_reg + 8'd1) == len_reg)
                                begin
                                    phase_next = PH_CSUM;
                                end
                            end
                            default:
                            begin
                                res_push = 1'b1;
                                if ((sum_reg + v8) == 8'h00)
                                begin
                                    res_next.kind = RK_OK;
                                    phase_next    = PH_WAIT;
                                end
                                else
                                begin
                                    res_next.kind = RK_BAD_SUM;
                                    phase_next    = PH_HALT;
                                end
                            end
                        endcase
                    end
                end
            endcase
        end
    end

    assign empty   = (out_cnt_reg == 2'd0);
    assign out_pop = pop && !empty;
    assign res_out = out_mem[out_rd_reg];

    always_comb
    begin
        out_wr_next  = res_push ? !out_wr_reg : out_wr_reg;
        out_rd_next  = out_pop ? !out_rd_reg : out_rd_reg;
        out_cnt_next = out_cnt_reg;
        if (res_push && !out_pop)
        begin
            out_cnt_next = out_cnt_reg + 2'd1;
        end
        else if (out_pop && !res_push)
        begin
            out_cnt_next = out_cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_WAIT;
            nib_cnt_reg <= 2'd0;
            high_reg    <= 12'h000;
            len_reg     <= 8'h00;
            addr_reg    <= 16'h0000;
            type_reg    <= 8'h00;
            idx_reg     <= 8'h00;
            sum_reg     <= 8'h00;
            out_wr_reg  <= 1'b0;
            out_rd_reg  <= 1'b0;
            out_cnt_reg <= 2'd0;
        end
        else
        begin
            phase_reg   <= phase_next;
            nib_cnt_reg <= nib_cnt_next;
            high_reg    <= high_next;
            len_reg     <= len_next;
            addr_reg    <= addr_next;
            type_reg    <= type_next;
            idx_reg     <= idx_next;
            sum_reg     <= sum_next;
            out_wr_reg  <= out_wr_next;
            out_rd_reg  <= out_rd_next;
            out_cnt_reg <= out_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_push)
        begin
            out_mem[out_wr_reg] <= res_next;
        end
    end

    a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_HALT |=> phase_reg == PH_HALT)
        else $error("parser left halt without reset");

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        res_push |-> out_cnt_reg != 2'd2)
        else $error("result written into full result queue");

    a_data_phase: assert property (@(posedge clk) disable iff (!rst_n)
        res_push && res_next.kind == RK_DATA |-> phase_reg == PH_DATA)
        else $error("data beat outside data phase");

    a_halt_silent: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_HALT |-> !res_push)
        else $error("result produced while halted");

endmodule

@@ tb/tb_hex_record_stream_parser_core.sv @@
`timescale 1ns / 100ps

module tb_hex_record_stream_parser_core;

    import hrsp_pkg::*;

    // Random character budget for the record stream after the directed table.
    localparam int RANDOM_ITEMS = 580;
    // Cycles without any accepted beat on either side before the run is declared hung.
    localparam int IDLE_LIMIT   = 500;
    // Quiet cycles after the last expected result, to catch stray results.
    localparam int SETTLE_CYCLES = 16;

    // Ways the single terminating record can end the stream (the block halts for good).
    typedef enum int {
        END_EOF,
        END_BAD_SUM,
        END_BAD_HEX
    } ending_t;

    // One row of the directed table: a character, and a typed result where one is known.
    typedef struct {
        logic [7:0] ch;
        bit         fixed;
        result_t    want;
    } dir_row_t;

    logic        clk     = 1'b0;
    logic        rst_n   = 1'b0;
    logic        push    = 1'b0;
    logic        full;
    logic [7:0]  in_char = 8'h00;
    logic        empty;
    logic        pop     = 1'b0;
    logic [2:0]  result_kind;
    logic [15:0] byte_address;
    logic [7:0]  data_byte;
    logic [7:0]  record_kind;

    // Results the parser is expected to produce, oldest first.
    result_t     pending_results[$];
    // Characters of the record being assembled for transmission.
    logic [7:0]  record_text[$];
    int          mismatch_count = 0;
    int          idle_cycles    = 0;
    bit          in_calm        = 1'b0;
    bit          out_calm       = 1'b0;

    // Parser state mirrored by the predictor; PH_HALT stands for the halted flag.
    phase_t      pr_phase = PH_WAIT;
    int          pr_nibs  = 0;
    logic [11:0] pr_hi    = '0;
    logic [7:0]  pr_len   = '0;
    logic [15:0] pr_addr  = '0;
    logic [7:0]  pr_type  = '0;
    logic [7:0]  pr_idx   = '0;
    logic [7:0]  pr_sum   = '0;

    // Directed stream: junk at both byte extremes, a two-byte record at the top of
    // the address space that wraps to zero with data FF then 00 and mixed-case
    // digits, then an empty record with type FF.
    dir_row_t dir_table [28] = '{
        '{8'h00, 1'b0, '0},
        '{8'hFF, 1'b0, '0},
        '{":",   1'b0, '0},
        '{"0",   1'b0, '0},
        '{"2",   1'b0, '0},
        '{"F",   1'b0, '0},
        '{"F",   1'b0, '0},
        '{"f",   1'b0, '0},
        '{"f",   1'b0, '0},
        '{"0",   1'b0, '0},
        '{"0",   1'b0, '0},
        '{"f",   1'b0, '0},
        '{"F",   1'b1, '{RK_DATA, 16'hFFFF, 8'hFF, 8'h00}},
        '{"0",   1'b0, '0},
        '{"0",   1'b1, '{RK_DATA, 16'h0000, 8'h00, 8'h00}},
        '{"0",   1'b0, '0},
        '{"1",   1'b1, '{RK_OK,   16'h0000, 8'h00, 8'h00}},
        '{":",   1'b0, '0},
        '{"0",   1'b0, '0},
        '{"0",   1'b0, '0},
        '{"0",   1'b0, '0},
        '{"0",   1'b0, '0},
        '{"0",   1'b0, '0},
        '{"0",   1'b0, '0},
        '{"F",   1'b0, '0},
        '{"F",   1'b0, '0},
        '{"0",   1'b0, '0},
        '{"1",   1'b1, '{RK_OK,   16'h0000, 8'h00, 8'hFF}}
    };

    hex_record_stream_parser_core u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .in_char      (in_char),
        .empty        (empty),
        .pop          (pop),
        .result_kind  (result_kind),
        .byte_address (byte_address),
        .data_byte    (data_byte),
        .record_kind  (record_kind)
    );

    always #2 clk = ~clk;

    // Return the nibble value of a hex digit in either case, or -1 for anything else.
    function automatic int hex_digit_value(input logic [7:0] c);
        if (c >= "0" && c <= "9")
            return int'(c - "0");
        if (c >= "A" && c <= "F")
            return int'(c - "A") + 10;
        if (c >= "a" && c <= "f")
            return int'(c - "a") + 10;
        return -1;
    endfunction

    // Advance the mirrored parser by one character; return 1 when it yields a result.
    function automatic bit parse_char(input logic [7:0] ch, output result_t res);
        int          nib;
        int          needed;
        logic [15:0] value;
        res = '0;
        if (pr_phase == PH_HALT)
            return 1'b0;
        // Skip everything up to a colon; the colon clears the record state.
        if (pr_phase == PH_WAIT)
        begin
            if (ch == COLON_CHAR)
            begin
                pr_phase = PH_COUNT;
                pr_nibs  = 0;
                pr_hi    = '0;
                pr_len   = '0;
                pr_addr  = '0;
                pr_type  = '0;
                pr_idx   = '0;
                pr_sum   = '0;
            end
            return 1'b0;
        end
        nib = hex_digit_value(ch);
        // Any non-digit inside a record, a colon included, halts the parser.
        if (nib < 0)
        begin
            pr_phase = PH_HALT;
            res      = '{RK_BAD_HEX, 16'h0000, 8'h00, pr_type};
            return 1'b1;
        end
        // Collect nibbles until the field is complete: four for the address, two otherwise.
        needed = (pr_phase == PH_ADDR) ? 4 : 2;
        if (pr_nibs + 1 < needed)
        begin
            pr_hi   = {pr_hi[7:0], nib[3:0]};
            pr_nibs = pr_nibs + 1;
            return 1'b0;
        end
        value   = {pr_hi, nib[3:0]};
        pr_nibs = 0;
        pr_hi   = '0;
        case (pr_phase)
            PH_COUNT:
            begin
                pr_len   = value[7:0];
                pr_sum   = pr_sum + value[7:0];
                pr_phase = PH_ADDR;
                return 1'b0;
            end
            PH_ADDR:
            begin
                pr_addr  = value;
                pr_sum   = pr_sum + value[7:0] + value[15:8];
                pr_phase = PH_TYPE;
                return 1'b0;
            end
            PH_TYPE:
            begin
                pr_type = value[7:0];
                pr_sum  = pr_sum + value[7:0];
                // End of file reports right away; no data or checksum follows.
                if (pr_type == EOF_TYPE)
                begin
                    pr_phase = PH_HALT;
                    res      = '{RK_EOF, 16'h0000, 8'h00, pr_type};
                    return 1'b1;
                end
                pr_idx   = '0;
                pr_phase = (pr_len == 8'd0) ? PH_CSUM : PH_DATA;
                return 1'b0;
            end
            PH_DATA:
            begin
                res      = '{RK_DATA, pr_addr + 16'(pr_idx), value[7:0], pr_type};
                pr_sum   = pr_sum + value[7:0];
                pr_idx   = pr_idx + 8'd1;
                if (pr_idx == pr_len)
                    pr_phase = PH_CSUM;
                return 1'b1;
            end
            default:
            begin
                if (8'(pr_sum + value[7:0]) == 8'd0)
                begin
                    pr_phase = PH_WAIT;
                    res      = '{RK_OK, 16'h0000, 8'h00, pr_type};
                end
                else
                begin
                    pr_phase = PH_HALT;
                    res      = '{RK_BAD_SUM, 16'h0000, 8'h00, pr_type};
                end
                return 1'b1;
            end
        endcase
    endfunction

    // Hex digit for a nibble, letters in a random case.
    function automatic logic [7:0] hex_char(input logic [3:0] n);
        logic [7:0] base;
        if (n < 4'd10)
            return "0" + 8'(n);
        base = $urandom_range(0, 1) ? "A" : "a";
        return base + 8'(n) - 8'd10;
    endfunction

    function automatic void append_hex_byte(input logic [7:0] b);
        record_text.push_back(hex_char(b[7:4]));
        record_text.push_back(hex_char(b[3:0]));
    endfunction

    // Assemble one record into record_text; stop after the type byte for end of file,
    // and offset the checksum by a nonzero amount when corrupt_sum is set.
    function automatic void build_record(input int count, input logic [15:0] addr,
                                         input logic [7:0] rtype, input bit corrupt_sum);
        logic [7:0] sum;
        logic [7:0] d;
        record_text.delete();
        record_text.push_back(COLON_CHAR);
        append_hex_byte(count[7:0]);
        append_hex_byte(addr[15:8]);
        append_hex_byte(addr[7:0]);
        append_hex_byte(rtype);
        sum = count[7:0] + addr[15:8] + addr[7:0] + rtype;
        if (rtype == EOF_TYPE)
            return;
        for (int i = 0; i < count; i++)
        begin
            d   = 8'($urandom);
            sum = sum + d;
            append_hex_byte(d);
        end
        sum = 8'd0 - sum;
        if (corrupt_sum)
            sum = sum + 8'($urandom_range(1, 255));
        append_hex_byte(sum);
    endfunction

    // Mostly short records; now and then a long one.
    function automatic int pick_count();
        if ($urandom_range(0, 29) == 0)
            return $urandom_range(100, 255);
        return $urandom_range(0, 8);
    endfunction

    // Bias some addresses to the top of the space so the byte index wraps.
    function automatic logic [15:0] pick_address();
        if ($urandom_range(0, 7) == 0)
            return 16'hFFF8 + 16'($urandom_range(0, 7));
        return 16'($urandom);
    endfunction

    // Half data records, the rest any type except end of file.
    function automatic logic [7:0] pick_type();
        logic [7:0] t;
        if ($urandom_range(0, 1) == 0)
            return 8'h00;
        do
            t = 8'($urandom);
        while (t == EOF_TYPE);
        return t;
    endfunction

    // Filler between records: any byte except a colon.
    function automatic logic [7:0] junk_char();
        logic [7:0] c;
        do
            c = 8'($urandom);
        while (c == COLON_CHAR);
        return c;
    endfunction

    // Draw a wait length; flip between calm (no wait) and busy stretches now and then.
    task automatic draw_wait(inout bit calm, output int cycles);
        if ($urandom_range(0, 29) == 0)
            calm = !calm;
        cycles = calm ? 0 : $urandom_range(0, 12);
    endtask

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        mismatch_count++;
    endtask

    // Drive one character beat: idle for a drawn gap, hold push until accepted, then
    // predict. Return at the accepting rising edge.
    task automatic send_char(input logic [7:0] ch, input bit fixed, input result_t fixed_res);
        int      gap;
        bit      has_res;
        result_t predicted;
        draw_wait(in_calm, gap);
        @(negedge clk);
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        push    <= 1'b1;
        in_char <= ch;
        do
            @(posedge clk);
        while (full);
        has_res = parse_char(ch, predicted);
        if (fixed)
            pending_results.push_back(fixed_res);
        else if (has_res)
            pending_results.push_back(predicted);
    endtask

    // Compare the result beat on the ports with the oldest expectation.
    task automatic check_result();
        result_t want;
        if (pending_results.size() == 0)
        begin
            report_mismatch($sformatf("result kind %0d with nothing expected", result_kind));
            return;
        end
        want = pending_results.pop_front();
        if (result_kind !== want.kind)
            report_mismatch($sformatf("result_kind %0d, want %0d", result_kind, want.kind));
        if (byte_address !== want.addr)
            report_mismatch($sformatf("byte_address %h, want %h", byte_address, want.addr));
        if (data_byte !== want.data)
            report_mismatch($sformatf("data_byte %h, want %h", data_byte, want.data));
        if (record_kind !== want.rkind)
            report_mismatch($sformatf("record_kind %h, want %h", record_kind, want.rkind));
    endtask

    // Result side: stall for a drawn number of cycles, then hold pop until a beat
    // is taken and check it.
    initial
    begin
        int stall;
        @(posedge rst_n);
        forever
        begin
            draw_wait(out_calm, stall);
            @(negedge clk);
            if (stall > 0)
            begin
                pop <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            pop <= 1'b1;
            do
                @(posedge clk);
            while (empty);
            check_result();
        end
    end

    // Watchdog: count cycles with no beat accepted on either side.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((push && !full) || (pop && !empty))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("status: fail");
                $finish;
            end
        end
    end

    initial
    begin
        int         random_sent;
        int         pos;
        int         junk_count;
        logic [7:0] bad;
        random_sent = 0;

        // Hold reset low, then release it away from the active edge.
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Walk the directed table.
        foreach (dir_table[i])
            send_char(dir_table[i].ch, dir_table[i].fixed, dir_table[i].want);

        // Well-formed records with random content, separated by junk.
        while (random_sent < RANDOM_ITEMS)
        begin
            junk_count = $urandom_range(0, 3);
            repeat (junk_count) send_char(junk_char(), 1'b0, '0);
            random_sent += junk_count;
            build_record(pick_count(), pick_address(), pick_type(), 1'b0);
            foreach (record_text[i])
                send_char(record_text[i], 1'b0, '0);
            random_sent += record_text.size();
        end

        // Close the stream with one record that halts the parser.
        case (ending_t'($urandom_range(0, 2)))
            END_EOF:
                build_record(pick_count(), pick_address(), EOF_TYPE, 1'b0);
            END_BAD_SUM:
                build_record(pick_count(), pick_address(), pick_type(), 1'b1);
            default:
            begin
                build_record(pick_count(), pick_address(), pick_type(), 1'b0);
                pos = $urandom_range(1, record_text.size() - 1);
                do
                    bad = 8'($urandom);
                while (hex_digit_value(bad) >= 0);
                record_text[pos] = bad;
            end
        endcase
        foreach (record_text[i])
            send_char(record_text[i], 1'b0, '0);

        // Once halted, every character must be dropped without a result.
        repeat (16) send_char(8'($urandom), 1'b0, '0);
        @(negedge clk);
        push <= 1'b0;

        // Drain the expected results, then stay quiet to catch strays.
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
